### src/ftba_pkg.sv
package ftba_pkg;

   // Channel count and field widths.
   localparam int CHANNELS  = 3;
   localparam int CAP_REGS  = 3;
   localparam int CH_IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int TIME_W    = 16;
   localparam int OP_W      = 3;
   localparam int CH_W      = 2;
   localparam int TOT_W     = 20;

   // Configuration register file.
   localparam int CFG_REGS  = 8;
   localparam int CFG_IDX_W = 3;

   localparam logic [CFG_IDX_W-1:0] REG_TARGET    = 3'd0;
   localparam logic [CFG_IDX_W-1:0] REG_MIN_SCALE = 3'd1;
   localparam logic [CFG_IDX_W-1:0] REG_MAX_SCALE = 3'd2;
   localparam logic [CFG_IDX_W-1:0] REG_ADAPT     = 3'd3;
   localparam logic [CFG_IDX_W-1:0] REG_IO_CAP    = 3'd4;
   localparam logic [CFG_IDX_W-1:0] REG_TOTAL_CAP = 3'd7;

   localparam logic [TIME_W-1:0] CFG_RESET [CFG_REGS] = '{
      16'd4267, 16'd2048, 16'd8192, 16'd6554, 16'd512, 16'd512, 16'd512, 16'd1024
   };

   // Operation codes.
   localparam logic [OP_W-1:0] OP_BEGIN_FRAME      = 3'd0;
   localparam logic [OP_W-1:0] OP_RESERVE_LEARNED  = 3'd1;
   localparam logic [OP_W-1:0] OP_RESERVE_EXPLICIT = 3'd2;
   localparam logic [OP_W-1:0] OP_COMMIT           = 3'd3;
   localparam logic [OP_W-1:0] OP_CANCEL           = 3'd4;

   // Arithmetic constants.
   localparam logic [TIME_W-1:0] SCALE_ONE  = 16'd4096;
   localparam logic [TIME_W-1:0] SEED_COST  = 16'd64;
   localparam logic [TIME_W-1:0] SMOOTH_Q16 = 16'd9830;
   localparam logic [TIME_W-1:0] MAX16      = 16'hFFFF;

   // Headroom divider: (target << 12) / last frame time.
   localparam int DIVIDEND_W = 28;
   localparam int DIV_STEPS  = DIVIDEND_W;
   localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

   typedef enum logic [3:0] {
      CMD_NONE,
      CMD_LOAD,
      CMD_DIV_INIT,
      CMD_DIV_STEP,
      CMD_ADAPT_MUL,
      CMD_ADAPT_APPLY,
      CMD_FRAME_CLEAR,
      CMD_CAP_CH,
      CMD_CAP_TOT,
      CMD_RESERVE,
      CMD_COMMIT_MUL,
      CMD_COMMIT_APPLY,
      CMD_CANCEL,
      CMD_OUT_LOAD
   } cmd_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            ch_ok;
      logic            adapt_en;
   } status_type;

endpackage

### src/ftba_ctrl.sv
module ftba_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  ftba_pkg::status_type status,
   output ftba_pkg::cmd_type    cmd
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_DIV_INIT,
      ST_DIV,
      ST_ADAPT_MUL,
      ST_ADAPT_APPLY,
      ST_FRAME_CLEAR,
      ST_CAP_CH,
      ST_CAP_TOT,
      ST_RESERVE,
      ST_COMMIT_MUL,
      ST_COMMIT_APPLY,
      ST_CANCEL,
      ST_DONE
   } state_type;

   state_type                          state_ff;
   state_type                          state_in;
   logic [ftba_pkg::DIV_CNT_W-1:0]     cnt_ff;
   logic [ftba_pkg::DIV_CNT_W-1:0]     cnt_in;
   logic                               rsp_tvalid_ff;
   logic                               rsp_tvalid_in;
   logic                               out_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign out_free   = !rsp_tvalid_ff || rsp_tready;

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      cmd           = ftba_pkg::CMD_NONE;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd      = ftba_pkg::CMD_LOAD;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (status.op == ftba_pkg::OP_BEGIN_FRAME) begin
               state_in = status.adapt_en ? ST_DIV_INIT : ST_FRAME_CLEAR;
            end else if ((status.op == ftba_pkg::OP_RESERVE_LEARNED ||
                          status.op == ftba_pkg::OP_RESERVE_EXPLICIT) && status.ch_ok) begin
               state_in = ST_CAP_CH;
            end else if (status.op == ftba_pkg::OP_COMMIT && status.ch_ok) begin
               state_in = ST_COMMIT_MUL;
            end else if (status.op == ftba_pkg::OP_CANCEL && status.ch_ok) begin
               state_in = ST_CANCEL;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DIV_INIT: begin
            cmd      = ftba_pkg::CMD_DIV_INIT;
            cnt_in   = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd    = ftba_pkg::CMD_DIV_STEP;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == ftba_pkg::DIV_CNT_W'(ftba_pkg::DIV_STEPS - 1)) begin
               state_in = ST_ADAPT_MUL;
            end
         end
         ST_ADAPT_MUL: begin
            cmd      = ftba_pkg::CMD_ADAPT_MUL;
            state_in = ST_ADAPT_APPLY;
         end
         ST_ADAPT_APPLY: begin
            cmd      = ftba_pkg::CMD_ADAPT_APPLY;
            state_in = ST_FRAME_CLEAR;
         end
         ST_FRAME_CLEAR: begin
            cmd      = ftba_pkg::CMD_FRAME_CLEAR;
            state_in = ST_DONE;
         end
         ST_CAP_CH: begin
            cmd      = ftba_pkg::CMD_CAP_CH;
            state_in = ST_CAP_TOT;
         end
         ST_CAP_TOT: begin
            cmd      = ftba_pkg::CMD_CAP_TOT;
            state_in = ST_RESERVE;
         end
         ST_RESERVE: begin
            cmd      = ftba_pkg::CMD_RESERVE;
            state_in = ST_DONE;
         end
         ST_COMMIT_MUL: begin
            cmd      = ftba_pkg::CMD_COMMIT_MUL;
            state_in = ST_COMMIT_APPLY;
         end
         ST_COMMIT_APPLY: begin
            cmd      = ftba_pkg::CMD_COMMIT_APPLY;
            state_in = ST_DONE;
         end
         ST_CANCEL: begin
            cmd      = ftba_pkg::CMD_CANCEL;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // Hold the finished result until the output register is free.
            if (out_free) begin
               cmd           = ftba_pkg::CMD_OUT_LOAD;
               rsp_tvalid_in = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cnt_ff        <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

endmodule

### src/ftba_dp.sv
module ftba_dp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  ftba_pkg::cmd_type                    cmd,
   output ftba_pkg::status_type                 status,
   input  logic [31:0]                          req_tdata,
   input  logic [4:0]                           req_tuser,
   input  logic                                 csr_we,
   input  logic [ftba_pkg::CFG_IDX_W-1:0]       csr_index,
   input  logic [ftba_pkg::TIME_W-1:0]          csr_wdata,
   output logic [63:0]                          rsp_tdata,
   output logic                                 rsp_tuser
);

   localparam int TW = ftba_pkg::TIME_W;
   localparam int DW = ftba_pkg::DIVIDEND_W;

   // Raise to the minimum first, then lower to the maximum.
   function automatic logic [TW-1:0] clamp_scale(input logic signed [TW+2:0] v,
                                                 input logic [TW-1:0] lo,
                                                 input logic [TW-1:0] hi);
      logic signed [TW+2:0] r;
      r = v;
      if (r < $signed({3'b000, lo})) r = $signed({3'b000, lo});
      if (r > $signed({3'b000, hi})) r = $signed({3'b000, hi});
      return r[TW-1:0];
   endfunction

   // Saturate to the unsigned 16-bit range.
   function automatic logic [TW-1:0] sat16(input logic signed [TW+2:0] v);
      logic [TW-1:0] r;
      if (v < 0) r = '0;
      else if (v > $signed({3'b000, ftba_pkg::MAX16})) r = ftba_pkg::MAX16;
      else r = v[TW-1:0];
      return r;
   endfunction

   function automatic logic [TW-1:0] adjust(input logic [TW-1:0] cur,
                                            input logic signed [TW+1:0] delta);
      logic signed [TW+2:0] v;
      v = $signed({3'b000, cur}) + $signed({delta[TW+1], delta});
      return sat16(v);
   endfunction

   logic [TW-1:0]                       cfg_ff [ftba_pkg::CFG_REGS];

   logic [ftba_pkg::OP_W-1:0]           op_ff;
   logic [ftba_pkg::CH_W-1:0]           ch_ff;
   logic [TW-1:0]                       tv_ff;
   logic [TW-1:0]                       ra_ff;

   logic [TW-1:0]                       scale_ff;
   logic [TW-1:0]                       usage_ff [ftba_pkg::CHANNELS];
   logic [TW-1:0]                       avg_ff [ftba_pkg::CHANNELS];
   logic [TW-1:0]                       rej_ff;
   logic                                granted_ff;
   logic [TW-1:0]                       amount_ff;

   logic [TW-1:0]                       rem_ff;
   logic [DW-1:0]                       quo_ff;
   logic signed [2*TW+1:0]              prod_ff;
   logic [2*TW-1:0]                     cap_ch_ff;
   logic [2*TW-1:0]                     cap_tot_ff;

   logic                                out_granted_ff;
   logic [TW-1:0]                       out_amount_ff;
   logic [TW-1:0]                       out_rej_ff;
   logic [TW-1:0]                       out_total_ff;
   logic [TW-1:0]                       out_scale_ff;

   logic                                ch_ok;
   logic [ftba_pkg::CH_IDX_W-1:0]       ch_idx;
   logic [TW-1:0]                       use_sel;
   logic [TW-1:0]                       avg_sel;
   logic [TW-1:0]                       chcap;
   logic [TW-1:0]                       est;
   logic [ftba_pkg::TOT_W-1:0]          tot;
   logic [TW-1:0]                       tot_sat;
   logic [TW:0]                         div_shift;
   logic                                div_fit;
   logic [DW-1:0]                       head;
   logic [TW-1:0]                       tgt;
   logic [TW-1:0]                       mul_u_a;
   logic [2*TW-1:0]                     mul_u_p;
   logic signed [TW:0]                  mul_s_a;
   logic signed [TW:0]                  mul_s_b;
   logic signed [2*TW+1:0]              mul_s_p;
   logic signed [2*TW+1:0]              prod_rnd;
   logic signed [TW+1:0]                step;
   logic [2*TW-1:0]                     need_ch;
   logic [2*TW-1:0]                     need_tot;
   logic                                over;
   logic                                untouched;

   assign ch_ok   = (int'(ch_ff) < ftba_pkg::CHANNELS);
   assign ch_idx  = ftba_pkg::CH_IDX_W'(ch_ff);
   assign use_sel = ch_ok ? usage_ff[ch_idx] : '0;
   assign avg_sel = ch_ok ? avg_ff[ch_idx] : '0;
   assign chcap   = (int'(ch_ff) < ftba_pkg::CAP_REGS)
                    ? cfg_ff[ftba_pkg::CFG_IDX_W'(int'(ftba_pkg::REG_IO_CAP) + int'(ch_ff))]
                    : '0;

   assign status.op       = op_ff;
   assign status.ch_ok    = ch_ok;
   assign status.adapt_en = (tv_ff != '0) && (cfg_ff[ftba_pkg::REG_TARGET] != '0);

   always_comb begin
      if (op_ff == ftba_pkg::OP_RESERVE_LEARNED) begin
         est = (avg_sel == '0) ? ftba_pkg::SEED_COST : avg_sel;
      end else begin
         est = tv_ff;
      end
   end

   always_comb begin
      tot = '0;
      for (int i = 0; i < ftba_pkg::CHANNELS; i++) begin
         tot = tot + ftba_pkg::TOT_W'(usage_ff[i]);
      end
   end
   assign tot_sat = (tot > ftba_pkg::TOT_W'(ftba_pkg::MAX16)) ? ftba_pkg::MAX16 : tot[TW-1:0];

   // One restoring divider step: the remainder stays below the divisor.
   assign div_shift = {rem_ff, quo_ff[DW-1]};
   assign div_fit   = (div_shift >= {1'b0, tv_ff});

   // Headroom clamp; the quotient can be far wider than a scale.
   always_comb begin
      head = quo_ff;
      if (head < DW'(cfg_ff[ftba_pkg::REG_MIN_SCALE])) head = DW'(cfg_ff[ftba_pkg::REG_MIN_SCALE]);
      if (head > DW'(cfg_ff[ftba_pkg::REG_MAX_SCALE])) head = DW'(cfg_ff[ftba_pkg::REG_MAX_SCALE]);
      tgt = head[TW-1:0];
   end

   // Shared unsigned multiplier for the scaled caps.
   assign mul_u_a = (cmd == ftba_pkg::CMD_CAP_CH) ? chcap : cfg_ff[ftba_pkg::REG_TOTAL_CAP];
   assign mul_u_p = mul_u_a * scale_ff;

   // Shared signed multiplier for the adaptation step and the cost smoothing.
   always_comb begin
      if (cmd == ftba_pkg::CMD_ADAPT_MUL) begin
         mul_s_a = $signed({1'b0, tgt}) - $signed({1'b0, scale_ff});
         mul_s_b = $signed({1'b0, cfg_ff[ftba_pkg::REG_ADAPT]});
      end else begin
         mul_s_a = $signed({1'b0, tv_ff}) - $signed({1'b0, avg_sel});
         mul_s_b = $signed({1'b0, ftba_pkg::SMOOTH_Q16});
      end
      mul_s_p = mul_s_a * mul_s_b;
   end

   // Divide by 65536, rounding half up: floor of (p + 32768) / 65536.
   assign prod_rnd = prod_ff + (2*TW+2)'(32768);
   assign step     = prod_rnd[2*TW+1:TW];

   assign need_ch   = {3'b000, {1'b0, use_sel} + {1'b0, est}, 12'b0};
   assign need_tot  = {tot + ftba_pkg::TOT_W'(est), 12'b0};
   assign over      = (need_ch > cap_ch_ff) || (need_tot > cap_tot_ff);
   assign untouched = (tot == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ftba_pkg::CFG_REGS; i++) begin
            cfg_ff[i] <= ftba_pkg::CFG_RESET[i];
         end
      end else if (csr_we) begin
         cfg_ff[csr_index] <= csr_wdata;
      end
   end

   // Item capture, divider and product registers carry no reset.
   always_ff @(posedge clock) begin
      if (cmd == ftba_pkg::CMD_LOAD) begin
         op_ff <= req_tuser[2:0];
         ch_ff <= req_tuser[4:3];
         tv_ff <= req_tdata[15:0];
         ra_ff <= req_tdata[31:16];
      end
      if (cmd == ftba_pkg::CMD_DIV_INIT) begin
         rem_ff <= '0;
         quo_ff <= {cfg_ff[ftba_pkg::REG_TARGET], 12'b0};
      end else if (cmd == ftba_pkg::CMD_DIV_STEP) begin
         rem_ff <= div_fit ? TW'(div_shift - {1'b0, tv_ff}) : div_shift[TW-1:0];
         quo_ff <= {quo_ff[DW-2:0], div_fit};
      end
      if (cmd == ftba_pkg::CMD_ADAPT_MUL || cmd == ftba_pkg::CMD_COMMIT_MUL) begin
         prod_ff <= mul_s_p;
      end
      if (cmd == ftba_pkg::CMD_CAP_CH) begin
         cap_ch_ff <= mul_u_p;
      end
      if (cmd == ftba_pkg::CMD_CAP_TOT) begin
         cap_tot_ff <= mul_u_p;
      end
      if (cmd == ftba_pkg::CMD_OUT_LOAD) begin
         out_granted_ff <= granted_ff;
         out_amount_ff  <= amount_ff;
         out_rej_ff     <= rej_ff;
         out_total_ff   <= tot_sat;
         out_scale_ff   <= scale_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff   <= ftba_pkg::SCALE_ONE;
         rej_ff     <= '0;
         granted_ff <= 1'b0;
         amount_ff  <= '0;
         for (int i = 0; i < ftba_pkg::CHANNELS; i++) begin
            usage_ff[i] <= '0;
            avg_ff[i]   <= '0;
         end
      end else begin
         case (cmd)
            ftba_pkg::CMD_LOAD: begin
               granted_ff <= 1'b0;
               amount_ff  <= '0;
            end
            ftba_pkg::CMD_ADAPT_APPLY: begin
               scale_ff <= clamp_scale($signed({3'b000, scale_ff}) + $signed({step[TW+1], step}),
                                       cfg_ff[ftba_pkg::REG_MIN_SCALE],
                                       cfg_ff[ftba_pkg::REG_MAX_SCALE]);
            end
            ftba_pkg::CMD_FRAME_CLEAR: begin
               rej_ff <= '0;
               for (int i = 0; i < ftba_pkg::CHANNELS; i++) begin
                  usage_ff[i] <= '0;
               end
            end
            ftba_pkg::CMD_RESERVE: begin
               if (!untouched && over) begin
                  if (rej_ff != ftba_pkg::MAX16) rej_ff <= rej_ff + 1'b1;
               end else begin
                  usage_ff[ch_idx] <= adjust(use_sel, $signed({2'b00, est}));
                  granted_ff       <= 1'b1;
                  amount_ff        <= est;
               end
            end
            ftba_pkg::CMD_COMMIT_MUL: begin
               usage_ff[ch_idx] <= adjust(use_sel,
                                          $signed({2'b00, tv_ff}) - $signed({2'b00, ra_ff}));
            end
            ftba_pkg::CMD_COMMIT_APPLY: begin
               if (avg_sel == '0) begin
                  avg_ff[ch_idx] <= tv_ff;
               end else begin
                  avg_ff[ch_idx] <= sat16($signed({3'b000, avg_sel}) +
                                          $signed({step[TW+1], step}));
               end
            end
            ftba_pkg::CMD_CANCEL: begin
               usage_ff[ch_idx] <= adjust(use_sel, -$signed({2'b00, ra_ff}));
            end
            default: begin
            end
         endcase
      end
   end

   assign rsp_tuser = out_granted_ff;
   assign rsp_tdata = {out_scale_ff, out_total_ff, out_rej_ff, out_amount_ff};

endmodule

### src/frame_time_budget_admission_unit.sv
// Frame time budget admission across three work channels. Times are in 1/256 ms and scales
// in Q4.12. Each request transaction yields exactly one response transaction. Items are
// worked one at a time. A begin frame that adapts the scale first runs the 28-step
// restoring divider, which forms target * 4096 / last frame time one quotient bit per
// cycle, then steps the scale toward the clamped headroom and clears the frame's usage
// and rejection count. A finished response is held in an output register, so the next
// request is taken while it waits. Configuration registers may be written only while no
// request is in flight.
module frame_time_budget_admission_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [31:0]                        req_tdata,  // time_value, reserved_amount
   input  logic [4:0]                         req_tuser,  // operation, channel
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // granted_amount, rejection_count, total_in_use, current_scale
   output logic [63:0]                        rsp_tdata,
   output logic                               rsp_tuser,  // granted
   input  logic                               csr_we,
   input  logic [ftba_pkg::CFG_IDX_W-1:0]     csr_index,
   input  logic [ftba_pkg::TIME_W-1:0]        csr_wdata
);

   ftba_pkg::cmd_type    cmd;
   ftba_pkg::status_type status;

   ftba_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   ftba_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

endmodule

### tb/sv/tb_frame_time_budget_admission_unit.sv
module tb_frame_time_budget_admission_unit;
   import ftba_pkg::*;

   localparam int CYCLE_LIMIT = 500_000;

   localparam logic [OP_W-1:0]      OP_NOP_FIRST = 3'd5;
   localparam logic [OP_W-1:0]      OP_NOP_LAST  = 3'd7;
   localparam logic [CH_W-1:0]      CH_IO        = 2'd0;
   localparam logic [CH_W-1:0]      CH_CPU       = 2'd1;
   localparam logic [CH_W-1:0]      CH_GPU       = 2'd2;
   localparam logic [CH_W-1:0]      CH_UNMAPPED  = 2'd3;
   localparam logic [CFG_IDX_W-1:0] REG_CPU_CAP  = REG_IO_CAP + 3'd1;
   localparam logic [CFG_IDX_W-1:0] REG_GPU_CAP  = REG_IO_CAP + 3'd2;

   typedef struct packed {
      logic              granted;
      logic [TIME_W-1:0] amount;
      logic [TIME_W-1:0] rejects;
      logic [TIME_W-1:0] in_use;
      logic [TIME_W-1:0] scale;
   } admission_outcome_t;

   logic                 clock;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [31:0]          req_tdata  = '0;   // time_value, reserved_amount
   logic [4:0]           req_tuser  = '0;   // operation, channel
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   // granted_amount, rejection_count, total_in_use, current_scale
   logic [63:0]          rsp_tdata;
   logic                 rsp_tuser;         // granted
   logic                 csr_we     = 1'b0;
   logic [CFG_IDX_W-1:0] csr_index  = '0;
   logic [TIME_W-1:0]    csr_wdata  = '0;

   frame_time_budget_admission_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // Mirror of the budget state and register file.
   logic [TIME_W-1:0] budget_regs   [CFG_REGS];
   logic [TIME_W-1:0] scale_q412;
   logic [TIME_W-1:0] chan_used     [CHANNELS];
   logic [TIME_W-1:0] chan_avg_cost [CHANNELS];
   logic [TIME_W-1:0] reject_cnt;

   admission_outcome_t outcome_q [$];

   int fail_count    = 0;
   int cycle_count   = 0;
   int n_items       = 0;
   int n_grants      = 0;
   int n_rejected    = 0;
   int n_settings    = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   function automatic longint clamp_scale(input longint v);
      longint lo, hi;
      lo = budget_regs[REG_MIN_SCALE];
      hi = budget_regs[REG_MAX_SCALE];
      // The lower bound is applied first, so the upper bound wins when they cross.
      if (v < lo) v = lo;
      if (v > hi) v = hi;
      return v;
   endfunction

   // Divide by 65536, rounding to nearest with ties toward plus infinity.
   function automatic longint round_q16(input longint prod);
      return (prod + 32768) >>> 16;
   endfunction

   function automatic longint usage_total();
      longint s;
      s = 0;
      for (int i = 0; i < CHANNELS; i++) s += chan_used[i];
      return s;
   endfunction

   function automatic void nudge_usage(input logic [CH_W-1:0] ch, input longint delta);
      longint v;
      v = chan_used[ch];
      v = v + delta;
      if (v < 0) v = 0;
      if (v > MAX16) v = MAX16;
      chan_used[ch] = v[TIME_W-1:0];
   endfunction

   function automatic admission_outcome_t apply_budget_item(input logic [OP_W-1:0] op,
      input logic [CH_W-1:0] ch, input logic [TIME_W-1:0] tv, input logic [TIME_W-1:0] ra);
      admission_outcome_t r;
      logic              ch_ok, over_ch, over_tot;
      logic [TIME_W-1:0] est;
      longint            head, tgt, cur, rate, smooth, avg, upd, used_all, t_val, r_amt;
      r      = '0;
      ch_ok  = (ch < CHANNELS);
      t_val  = tv;
      r_amt  = ra;
      smooth = SMOOTH_Q16;
      if (op == OP_BEGIN_FRAME) begin
         if (tv != 0 && budget_regs[REG_TARGET] != 0) begin
            head = budget_regs[REG_TARGET];
            head = (head * SCALE_ONE) / tv;
            tgt  = clamp_scale(head);
            cur  = scale_q412;
            rate = budget_regs[REG_ADAPT];
            cur  = clamp_scale(cur + round_q16((tgt - cur) * rate));
            scale_q412 = cur[TIME_W-1:0];
         end
         for (int i = 0; i < CHANNELS; i++) chan_used[i] = '0;
         reject_cnt = '0;
      end else if ((op == OP_RESERVE_LEARNED || op == OP_RESERVE_EXPLICIT) && ch_ok) begin
         if (op == OP_RESERVE_LEARNED) begin
            est = (chan_avg_cost[ch] == 0) ? SEED_COST : chan_avg_cost[ch];
         end else begin
            est = tv;
         end
         used_all = usage_total();
         over_ch  = (64'(chan_used[ch]) + est) * SCALE_ONE >
                    64'(budget_regs[REG_IO_CAP + ch]) * scale_q412;
         over_tot = (64'(used_all) + est) * SCALE_ONE >
                    64'(budget_regs[REG_TOTAL_CAP]) * scale_q412;
         // Nothing spent yet this frame lets any job through.
         if (used_all != 0 && (over_ch || over_tot)) begin
            if (reject_cnt != MAX16) reject_cnt++;
         end else begin
            nudge_usage(ch, est);
            r.granted = 1'b1;
            r.amount  = est;
         end
      end else if (op == OP_COMMIT && ch_ok) begin
         nudge_usage(ch, t_val - r_amt);
         avg = chan_avg_cost[ch];
         if (avg == 0) begin
            chan_avg_cost[ch] = tv;
         end else begin
            upd = avg + round_q16((t_val - avg) * smooth);
            if (upd < 0) upd = 0;
            if (upd > MAX16) upd = MAX16;
            chan_avg_cost[ch] = upd[TIME_W-1:0];
         end
      end else if (op == OP_CANCEL && ch_ok) begin
         nudge_usage(ch, -r_amt);
      end
      used_all  = usage_total();
      r.rejects = reject_cnt;
      r.in_use  = (used_all > MAX16) ? MAX16 : used_all[TIME_W-1:0];
      r.scale   = scale_q412;
      return r;
   endfunction

   function automatic logic [TIME_W-1:0] random_time();
      case ($urandom_range(0, 9))
         0: begin
            return '0;
         end
         1: begin
            return MAX16;
         end
         2, 3: begin
            return TIME_W'($urandom);
         end
         default: begin
            return TIME_W'($urandom_range(1, 600));
         end
      endcase
   endfunction

   task automatic check_field(input string what, input int want, input int got);
      if (want != got) begin
         fail_count++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      end
   endtask

   always @(posedge clock) begin : rsp_monitor
      admission_outcome_t want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (outcome_q.size() == 0) begin
               fail_count++;
               $display("%0t: response transaction with none pending, expected none, actual %h",
                        $time, rsp_tdata);
            end else begin
               want = outcome_q.pop_front();
               check_field("granted", want.granted, rsp_tuser);
               check_field("granted_amount", want.amount, rsp_tdata[15:0]);
               check_field("rejection_count", want.rejects, rsp_tdata[31:16]);
               check_field("total_in_use", want.in_use, rsp_tdata[47:32]);
               check_field("current_scale", want.scale, rsp_tdata[63:48]);
            end
         end
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // Valid stays high after a transaction so that back-to-back items need no gap.
   task automatic send_item(input logic [OP_W-1:0] op, input logic [CH_W-1:0] ch,
      input logic [TIME_W-1:0] tv, input logic [TIME_W-1:0] ra, output admission_outcome_t got);
      int gap;
      gap = 0;
      while ($urandom_range(0, 99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {ra, tv};
      req_tuser  <= {ch, op};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      got = apply_budget_item(op, ch, tv, ra);
      outcome_q.push_back(got);
      n_items++;
      if ((op == OP_RESERVE_LEARNED || op == OP_RESERVE_EXPLICIT) && ch < CHANNELS) begin
         if (got.granted) n_grants++;
         else n_rejected++;
      end
   endtask

   task automatic drain_responses();
      req_tvalid <= 1'b0;
      while (outcome_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic load_budget_regs(input logic [TIME_W-1:0] target, input logic [TIME_W-1:0] lo,
      input logic [TIME_W-1:0] hi, input logic [TIME_W-1:0] rate, input logic [TIME_W-1:0] io,
      input logic [TIME_W-1:0] cpu, input logic [TIME_W-1:0] gpu, input logic [TIME_W-1:0] total);
      logic [TIME_W-1:0] vals [CFG_REGS];
      vals[REG_TARGET]    = target;
      vals[REG_MIN_SCALE] = lo;
      vals[REG_MAX_SCALE] = hi;
      vals[REG_ADAPT]     = rate;
      vals[REG_IO_CAP]    = io;
      vals[REG_CPU_CAP]   = cpu;
      vals[REG_GPU_CAP]   = gpu;
      vals[REG_TOTAL_CAP] = total;
      drain_responses();
      for (int i = 0; i < CFG_REGS; i++) begin
         csr_we    <= 1'b1;
         csr_index <= CFG_IDX_W'(i);
         csr_wdata <= vals[i];
         @(posedge clock);
         budget_regs[i] = vals[i];
      end
      csr_we <= 1'b0;
      @(posedge clock);
      n_settings++;
   endtask

   // One frame: a begin frame, then reserves paired with commits or cancels of what
   // was granted, with some stray and malformed transactions mixed in.
   task automatic run_frame(input int jobs, input int noise_pct);
      admission_outcome_t o;
      logic [CH_W-1:0]    open_ch  [$];
      logic [TIME_W-1:0]  open_amt [$];
      logic [TIME_W-1:0]  tv, ra;
      logic [OP_W-1:0]    op;
      logic [CH_W-1:0]    ch;
      longint             a;
      int                 pick, k;
      if ($urandom_range(0, 1)) begin
         tv = random_time();
      end else begin
         a = budget_regs[REG_TARGET];
         a = a + longint'($urandom_range(0, 2000)) - 1000;
         if (a < 0) a = 0;
         if (a > MAX16) a = MAX16;
         tv = a[TIME_W-1:0];
      end
      send_item(OP_BEGIN_FRAME, CH_W'($urandom_range(0, 3)), tv, TIME_W'($urandom), o);
      for (int j = 0; j < jobs; j++) begin
         pick = $urandom_range(0, 99);
         if (pick < noise_pct) begin
            send_item(OP_W'($urandom_range(OP_BEGIN_FRAME, OP_NOP_LAST)),
                      CH_W'($urandom_range(CH_IO, CH_UNMAPPED)),
                      TIME_W'($urandom), TIME_W'($urandom), o);
         end else if (pick < 55 || open_ch.size() == 0) begin
            ch = CH_W'($urandom_range(CH_IO, CH_GPU));
            op = $urandom_range(0, 1) ? OP_RESERVE_LEARNED : OP_RESERVE_EXPLICIT;
            tv = ($urandom_range(0, 9) == 0) ? random_time() : TIME_W'($urandom_range(1, 400));
            send_item(op, ch, tv, TIME_W'($urandom), o);
            if (o.granted) begin
               open_ch.push_back(ch);
               open_amt.push_back(o.amount);
            end
         end else begin
            k  = $urandom_range(0, open_ch.size() - 1);
            ra = ($urandom_range(0, 19) == 0) ? TIME_W'($urandom) : open_amt[k];
            if ($urandom_range(0, 9) < 7) begin
               a = open_amt[k];
               a = a + longint'($urandom_range(0, 200)) - 100;
               if (a < 0) a = 0;
               if (a > MAX16) a = MAX16;
               send_item(OP_COMMIT, open_ch[k], a[TIME_W-1:0], ra, o);
            end else begin
               send_item(OP_CANCEL, open_ch[k], TIME_W'($urandom), ra, o);
            end
            open_ch.delete(k);
            open_amt.delete(k);
         end
      end
   endtask

   task automatic test_directed_cases();
      admission_outcome_t o;
      // Empty frame admits the seed cost, then the caps start to bite.
      send_item(OP_RESERVE_LEARNED, CH_IO, '0, '0, o);
      send_item(OP_RESERVE_EXPLICIT, CH_CPU, MAX16, MAX16, o);
      send_item(OP_RESERVE_EXPLICIT, CH_GPU, '0, MAX16, o);
      send_item(OP_RESERVE_EXPLICIT, CH_IO, 16'd448, '0, o);
      send_item(OP_RESERVE_EXPLICIT, CH_IO, 16'd1, '0, o);
      send_item(OP_RESERVE_LEARNED, CH_UNMAPPED, MAX16, MAX16, o);
      // Usage saturation at both ends and learning of the average cost.
      send_item(OP_COMMIT, CH_IO, MAX16, '0, o);
      send_item(OP_COMMIT, CH_CPU, 16'd100, '0, o);
      send_item(OP_COMMIT, CH_CPU, '0, 16'd300, o);
      send_item(OP_CANCEL, CH_GPU, '0, MAX16, o);
      send_item(OP_CANCEL, CH_IO, '0, 16'd1000, o);
      send_item(OP_COMMIT, CH_UNMAPPED, MAX16, '0, o);
      send_item(OP_CANCEL, CH_UNMAPPED, '0, MAX16, o);
      send_item(OP_NOP_FIRST, CH_UNMAPPED, MAX16, MAX16, o);
      send_item(OP_NOP_FIRST + 3'd1, CH_IO, MAX16, MAX16, o);
      send_item(OP_NOP_LAST, CH_GPU, MAX16, MAX16, o);
      send_item(OP_RESERVE_LEARNED, CH_IO, '0, '0, o);
      // Adaptation skipped, then with the headroom pinned to the upper and lower bounds, then neutral.
      send_item(OP_BEGIN_FRAME, CH_IO, '0, '0, o);
      send_item(OP_BEGIN_FRAME, CH_IO, 16'd1, '0, o);
      send_item(OP_BEGIN_FRAME, CH_GPU, MAX16, MAX16, o);
      send_item(OP_BEGIN_FRAME, CH_CPU, 16'd4267, '0, o);
      send_item(OP_RESERVE_EXPLICIT, CH_GPU, MAX16, '0, o);
      send_item(OP_RESERVE_LEARNED, CH_CPU, '0, '0, o);
      send_item(OP_COMMIT, CH_GPU, MAX16, '0, o);
      send_item(OP_CANCEL, CH_GPU, '0, '0, o);
   endtask

   task automatic test_register_sweep();
      for (int s = 0; s < 9; s++) begin
         case (s)
            0: begin
               load_budget_regs('0, '0, '0, '0, '0, '0, '0, '0);
            end
            1: begin
               load_budget_regs(MAX16, MAX16, MAX16, MAX16, MAX16, MAX16, MAX16, MAX16);
            end
            2: begin
               // Lower bound above the upper one.
               load_budget_regs(16'd4267, 16'd40000, 16'd1000, MAX16, 16'd300, 16'd600,
                                16'd900, 16'd1500);
            end
            3: begin
               load_budget_regs(16'd4267, '0, MAX16, MAX16, 16'd512, 16'd512, 16'd512,
                                16'd1024);
            end
            6: begin
               load_budget_regs(16'd2000, 16'd1024, 16'd16384, 16'd32768, MAX16, 16'd100,
                                MAX16, MAX16);
            end
            8: begin
               load_budget_regs(CFG_RESET[0], CFG_RESET[1], CFG_RESET[2], CFG_RESET[3],
                                CFG_RESET[4], CFG_RESET[5], CFG_RESET[6], CFG_RESET[7]);
            end
            default: begin
               load_budget_regs(TIME_W'($urandom), TIME_W'($urandom), TIME_W'($urandom),
                                TIME_W'($urandom), TIME_W'($urandom), TIME_W'($urandom),
                                TIME_W'($urandom), TIME_W'($urandom));
            end
         endcase
         repeat (3) run_frame(22, 10);
      end
   endtask

   task automatic test_frame_sequences(input int frames);
      load_budget_regs(TIME_W'($urandom_range(2000, 8000)), TIME_W'($urandom_range(1024, 4096)),
                       TIME_W'($urandom_range(6000, 16384)), TIME_W'($urandom_range(2000, 40000)),
                       TIME_W'($urandom_range(200, 900)), TIME_W'($urandom_range(200, 900)),
                       TIME_W'($urandom_range(200, 900)), TIME_W'($urandom_range(600, 2000)));
      repeat (frames) run_frame($urandom_range(10, 30), 10);
   endtask

   // With every cap at zero only the first job of the frame gets through, so every
   // later reserve in the frame adds to the rejection count.
   task automatic test_zero_caps();
      admission_outcome_t o;
      load_budget_regs(16'd4267, 16'd2048, 16'd8192, 16'd6554, '0, '0, '0, '0);
      send_item(OP_BEGIN_FRAME, CH_IO, 16'd4267, '0, o);
      send_item(OP_RESERVE_EXPLICIT, CH_IO, 16'd1, '0, o);
      repeat (80) begin
         send_item($urandom_range(0, 1) ? OP_RESERVE_LEARNED : OP_RESERVE_EXPLICIT,
                   CH_W'($urandom_range(CH_IO, CH_GPU)), TIME_W'($urandom),
                   TIME_W'($urandom), o);
      end
      send_item(OP_BEGIN_FRAME, CH_IO, 16'd4267, '0, o);
      send_item(OP_RESERVE_EXPLICIT, CH_CPU, 16'd10, '0, o);
      send_item(OP_RESERVE_EXPLICIT, CH_CPU, 16'd10, '0, o);
   endtask

   initial begin
      for (int i = 0; i < CFG_REGS; i++) budget_regs[i] = CFG_RESET[i];
      for (int i = 0; i < CHANNELS; i++) begin
         chan_used[i]     = '0;
         chan_avg_cost[i] = '0;
      end
      scale_q412 = SCALE_ONE;
      reject_cnt = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 6;
      recv_idle_pct = 81;
      test_directed_cases();
      test_register_sweep();

      send_idle_pct = 81;
      recv_idle_pct = 6;
      test_frame_sequences(24);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_frame_sequences(20);
      test_zero_caps();

      drain_responses();
      repeat (40) @(posedge clock);
      $display("Sent %0d request transactions under %0d register settings and three idle mixes.",
               n_items, n_settings);
      $display("Reserves granted %0d, rejected %0d, including a frame with every cap at zero.",
               n_grants, n_rejected);
      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
